### sv/bbr_pkg.sv
// Shared types and constants for the 3x3 RGB box blur.
// Used by box_blur_3x3_rgb and its port checker; depends on nothing.
package bbr_pkg;

  // Largest frame the line stores can hold
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  // Widths of sizes, counters and sums
  localparam int SIZE_W = 12;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int CHAN_W = 8;
  localparam int PIX_W  = 3 * CHAN_W;
  localparam int SUM_W  = 12;

  // Divide by nine as multiply by a rounded-up reciprocal and shift
  localparam int                 RECIP9_W     = 13;
  localparam logic [RECIP9_W-1:0] RECIP9       = 13'd7282;
  localparam int                 RECIP9_SHIFT = 16;
  localparam int                 PROD_W       = SUM_W + RECIP9_W;

  // Configuration register indexes
  localparam int                  CFG_IDX_W        = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // Register reset values
  localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = 12'd800;
  localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = 12'd600;

  // Request kinds
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd255;

  typedef struct packed {
    logic              req_type;
    logic [CHAN_W-1:0] in_red;
    logic [CHAN_W-1:0] in_green;
    logic [CHAN_W-1:0] in_blue;
  } in_req_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_alpha;
    logic              last_of_frame;
  } out_res_t;

  // Zero counts as one, anything above the maximum counts as the maximum
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] max_v);
    logic [SIZE_W-1:0] res;
    if (v == '0) begin
      res = SIZE_W'(1);
    end else if (v > max_v) begin
      res = max_v;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

### sv/box_blur_3x3_rgb.sv
// Streaming 3x3 box blur over RGB frames in raster order.
// Depends on bbr_pkg for payload types, constants and size clamping.
//
// Usage:
//   The in_ channel carries requests: a pixel (req_type = pixel) or a flush
//   tick. Pixels of one frame go in raster order; the result for pixel p
//   leaves once request p + W + 1 has been taken, so W + 1 flush requests
//   drain the last results of a frame. The final result is marked with
//   last_of_frame, after which the next pixel starts a new frame.
//   The frame size is taken from frame_width and frame_height (cfg_ port)
//   when the first pixel of a frame arrives. Pixels past the frame size
//   and flushes with the frame not yet filled are dropped with no result.
//   Throughput is one request per cycle while in_stall is low. After the
//   request causing it is taken, a result reaches out_ by way of one
//   register that holds the masked neighbour sums and then one that holds
//   the divided result. The line store read for the next pixel is issued
//   in the cycle before, from the column count.
//   Reset clears all counters and the window and takes no clearing pass;
//   the line stores are only ever read at entries already written or at
//   neighbours that fall outside the frame. While the receiver stalls, the
//   result holds and one more result can collect behind it; only then is
//   in_stall raised.
module box_blur_3x3_rgb (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  bbr_pkg::in_req_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output bbr_pkg::out_res_t               out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bbr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bbr_pkg::SIZE_W-1:0]      cfg_data
);

  // Configuration and frame size in use
  logic [bbr_pkg::SIZE_W-1:0] frame_width_r, frame_height_r;
  logic [bbr_pkg::SIZE_W-1:0] act_w_r, act_w_nxt, act_h_r, act_h_nxt;
  logic [bbr_pkg::SIZE_W-1:0] act_w, act_h;

  // Raster counters
  logic [bbr_pkg::COL_W-1:0]  in_col_r, in_col_nxt;
  logic [bbr_pkg::SIZE_W-1:0] in_row_r, in_row_nxt;
  logic [bbr_pkg::COL_W-1:0]  out_col_r, out_col_nxt;
  logic [bbr_pkg::ROW_W-1:0]  out_row_r, out_row_nxt;
  logic [bbr_pkg::SIZE_W-1:0] fill_r, fill_nxt;

  // Line stores and their prefetched read data
  logic [bbr_pkg::PIX_W-1:0] upper_mem  [bbr_pkg::MAX_WIDTH];
  logic [bbr_pkg::PIX_W-1:0] middle_mem [bbr_pkg::MAX_WIDTH];
  logic [bbr_pkg::PIX_W-1:0] up_q_r, mid_q_r, byp_up_r, byp_mid_r;
  logic                      byp_r;
  logic [bbr_pkg::COL_W-1:0] rd_addr;
  logic [bbr_pkg::PIX_W-1:0] up_rd, mid_rd;

  // 3x3 window
  logic [bbr_pkg::PIX_W-1:0] win_r   [3][3];
  logic [bbr_pkg::PIX_W-1:0] win_nxt [3][3];

  // Request decode
  logic                      accept, is_pixel, frame_idle, row_open, adv;
  logic [bbr_pkg::PIX_W-1:0] pix;
  logic [bbr_pkg::SIZE_W-1:0] in_col_inc;
  logic                      col_wrap, filling;
  logic                      top_edge, bottom_edge, left_edge, right_edge, last;
  logic                      res;

  // Sum stage and result stage
  logic [bbr_pkg::SUM_W-1:0] sum_nxt [3];
  logic [bbr_pkg::SUM_W-1:0] s1_sum_r [3];
  logic                      s1_valid_r, s1_last_r;
  logic                      out_load;
  logic [bbr_pkg::PROD_W-1:0] prod [3];
  logic                      out_valid_r;
  bbr_pkg::out_res_t         out_data_r;

  assign cfg_ready = 1'b1;

  // Decode the request and the frame size it runs under
  assign accept     = in_valid && !in_stall;
  assign is_pixel   = (in_data.req_type == bbr_pkg::REQ_PIXEL);
  assign frame_idle = (in_col_r == '0) && (in_row_r == '0) && (fill_r == '0);
  assign act_w = (is_pixel && frame_idle)
               ? bbr_pkg::clamp_size(frame_width_r, bbr_pkg::SIZE_W'(bbr_pkg::MAX_WIDTH))
               : act_w_r;
  assign act_h = (is_pixel && frame_idle)
               ? bbr_pkg::clamp_size(frame_height_r, bbr_pkg::SIZE_W'(bbr_pkg::MAX_HEIGHT))
               : act_h_r;
  assign row_open = (in_row_r < act_h);
  assign adv      = accept && (is_pixel ? row_open : !row_open);
  assign pix      = is_pixel ? {in_data.in_red, in_data.in_green, in_data.in_blue} : '0;

  // Take the line store data, or the value just written at the same column
  assign up_rd  = byp_r ? byp_up_r  : up_q_r;
  assign mid_rd = byp_r ? byp_mid_r : mid_q_r;

  // Position tests
  assign in_col_inc  = {1'b0, in_col_r} + bbr_pkg::SIZE_W'(1);
  assign col_wrap    = (in_col_inc >= act_w);
  assign filling     = (fill_r < act_w + bbr_pkg::SIZE_W'(1));
  assign top_edge    = (out_row_r == '0);
  assign bottom_edge = ({1'b0, out_row_r} + bbr_pkg::SIZE_W'(1) >= act_h);
  assign left_edge   = (out_col_r == '0);
  assign right_edge  = ({1'b0, out_col_r} + bbr_pkg::SIZE_W'(1) >= act_w);
  assign last        = bottom_edge && right_edge;
  assign res         = adv && !filling;

  // Shift the window one column and bring in the new column
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        win_nxt[r][c] = win_r[r][c];
      end
    end
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        win_nxt[r][0] = win_r[r][1];
        win_nxt[r][1] = win_r[r][2];
      end
      win_nxt[0][2] = up_rd;
      win_nxt[1][2] = mid_rd;
      win_nxt[2][2] = pix;
    end
  end

  // Sum the in-frame neighbours per channel
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum_nxt[ch] = '0;
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (!((r == 0) && top_edge) && !((r == 2) && bottom_edge) &&
            !((c == 0) && left_edge) && !((c == 2) && right_edge)) begin
          sum_nxt[0] = sum_nxt[0] + bbr_pkg::SUM_W'(win_nxt[r][c][23:16]);
          sum_nxt[1] = sum_nxt[1] + bbr_pkg::SUM_W'(win_nxt[r][c][15:8]);
          sum_nxt[2] = sum_nxt[2] + bbr_pkg::SUM_W'(win_nxt[r][c][7:0]);
        end
      end
    end
  end

  // Advance the raster counters; restart them after the last result
  always_comb begin
    act_w_nxt   = act_w_r;
    act_h_nxt   = act_h_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    fill_nxt    = fill_r;
    if (adv) begin
      act_w_nxt  = act_w;
      act_h_nxt  = act_h;
      in_col_nxt = col_wrap ? '0 : in_col_inc[bbr_pkg::COL_W-1:0];
      if (col_wrap && row_open) begin
        in_row_nxt = in_row_r + bbr_pkg::SIZE_W'(1);
      end
      if (filling) begin
        fill_nxt = fill_r + bbr_pkg::SIZE_W'(1);
      end else if (last) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
        fill_nxt    = '0;
      end else if (right_edge) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + bbr_pkg::ROW_W'(1);
      end else begin
        out_col_nxt = out_col_r + bbr_pkg::COL_W'(1);
      end
    end
  end

  // Prefetch the column the next request will use
  assign rd_addr = rst_n ? in_col_nxt : '0;

  // Line stores: write the current column, read the next one
  always_ff @(posedge clk) begin
    if (adv) begin
      upper_mem[in_col_r]  <= mid_rd;
      middle_mem[in_col_r] <= pix;
    end
    up_q_r    <= upper_mem[rd_addr];
    mid_q_r   <= middle_mem[rd_addr];
    byp_up_r  <= mid_rd;
    byp_mid_r <= pix;
  end

  // Hand-off between sum stage and result register
  assign out_load = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !out_load;

  // Divide each sum by nine
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = bbr_pkg::PROD_W'(s1_sum_r[ch]) * bbr_pkg::PROD_W'(bbr_pkg::RECIP9);
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= bbr_pkg::FRAME_WIDTH_RST;
      frame_height_r <= bbr_pkg::FRAME_HEIGHT_RST;
      act_w_r        <= bbr_pkg::FRAME_WIDTH_RST;
      act_h_r        <= bbr_pkg::FRAME_HEIGHT_RST;
      in_col_r       <= '0;
      in_row_r       <= '0;
      out_col_r      <= '0;
      out_row_r      <= '0;
      fill_r         <= '0;
      byp_r          <= 1'b0;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          bbr_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
          bbr_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
          default: ;
        endcase
      end
      act_w_r     <= act_w_nxt;
      act_h_r     <= act_h_nxt;
      in_col_r    <= in_col_nxt;
      in_row_r    <= in_row_nxt;
      out_col_r   <= out_col_nxt;
      out_row_r   <= out_row_nxt;
      fill_r      <= fill_nxt;
      byp_r       <= adv && (in_col_r == rd_addr);
      s1_valid_r  <= res || (s1_valid_r && !out_load);
      out_valid_r <= out_load || (out_valid_r && out_stall);
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= win_nxt[r][c];
        end
      end
    end
  end

  // Sum stage and result payload
  always_ff @(posedge clk) begin
    if (res) begin
      for (int ch = 0; ch < 3; ch++) begin
        s1_sum_r[ch] <= sum_nxt[ch];
      end
      s1_last_r <= last;
    end
    if (out_load) begin
      out_data_r.out_red       <= prod[0][bbr_pkg::RECIP9_SHIFT +: bbr_pkg::CHAN_W];
      out_data_r.out_green     <= prod[1][bbr_pkg::RECIP9_SHIFT +: bbr_pkg::CHAN_W];
      out_data_r.out_blue      <= prod[2][bbr_pkg::RECIP9_SHIFT +: bbr_pkg::CHAN_W];
      out_data_r.out_alpha     <= bbr_pkg::ALPHA_OPAQUE;
      out_data_r.last_of_frame <= s1_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### sv/bbr_checker.sv
// Port-level checks for box_blur_3x3_rgb, attached by the bind below.
// Depends on bbr_pkg for the payload types.
module bbr_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input bbr_pkg::out_res_t             out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // Drop all results at reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A new result follows a request taken earlier, by way of the sum and result registers
  a_rose_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result appeared without a request");

  // Accept requests whenever the result register is empty
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("request stalled with output empty");

  // Alpha is always opaque
  a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.out_alpha == bbr_pkg::ALPHA_OPAQUE)
    else $error("result alpha not opaque");

endmodule

bind box_blur_3x3_rgb bbr_checker u_bbr_checker (.*);

### dv/tb_box_blur_3x3_rgb.sv
// Self-checking testbench for box_blur_3x3_rgb: drives pixel and flush requests,
// predicts the blurred frame in a scoreboard class and checks every result.
// Depends on bbr_pkg and the box_blur_3x3_rgb RTL.
module tb_box_blur_3x3_rgb;
  import bbr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  // Indexes the block decodes to no register
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

  // Predicts blurred pixels and holds them until the block returns them
  class blurred_pixel_book;
    bit [PIX_W-1:0]  upper_line[MAX_WIDTH];
    bit [PIX_W-1:0]  mid_line[MAX_WIDTH];
    bit [PIX_W-1:0]  win[3][3];
    int unsigned     in_col, in_row, out_col, out_row, fill;
    bit [SIZE_W-1:0] reg_w, reg_h;
    int unsigned     frame_w, frame_h;
    out_res_t        blurred_q[$];
    int unsigned     errors, checked;

    function new();
      reg_w   = FRAME_WIDTH_RST;
      reg_h   = FRAME_HEIGHT_RST;
      frame_w = fit_size(reg_w, MAX_WIDTH);
      frame_h = fit_size(reg_h, MAX_HEIGHT);
      restart();
    endfunction

    function int unsigned fit_size(bit [SIZE_W-1:0] v, int unsigned lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return v;
    endfunction

    function void restart();
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
      fill    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
      if (idx == REG_FRAME_WIDTH) begin
        reg_w = val;
      end else if (idx == REG_FRAME_HEIGHT) begin
        reg_h = val;
      end
    endfunction

    // Shift one pixel through the window and line stores; emit a result once primed
    function void push_pixel(bit [PIX_W-1:0] pix);
      int unsigned x, r, c, sum_r, sum_g, sum_b;
      bit          last;
      out_res_t    res;
      x = in_col;
      for (r = 0; r < 3; r++) begin
        win[r][0] = win[r][1];
        win[r][1] = win[r][2];
      end
      win[0][2]     = upper_line[x];
      win[1][2]     = mid_line[x];
      win[2][2]     = pix;
      upper_line[x] = mid_line[x];
      mid_line[x]   = pix;
      in_col++;
      if (in_col >= frame_w) begin
        in_col = 0;
        if (in_row < frame_h) in_row++;
      end
      if (fill < frame_w + 1) begin
        fill++;
        return;
      end
      // Sum the neighbours inside the frame; outside ones count as zero
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      for (r = 0; r < 3; r++) begin
        if (r == 0 && out_row == 0) continue;
        if (r == 2 && out_row + 1 >= frame_h) continue;
        for (c = 0; c < 3; c++) begin
          if (c == 0 && out_col == 0) continue;
          if (c == 2 && out_col + 1 >= frame_w) continue;
          sum_r += win[r][c][23:16];
          sum_g += win[r][c][15:8];
          sum_b += win[r][c][7:0];
        end
      end
      last              = (out_row + 1 >= frame_h) && (out_col + 1 >= frame_w);
      res.out_red       = 8'(sum_r / 9);
      res.out_green     = 8'(sum_g / 9);
      res.out_blue      = 8'(sum_b / 9);
      res.out_alpha     = ALPHA_OPAQUE;
      res.last_of_frame = last;
      blurred_q.push_back(res);
      if (last) begin
        restart();
      end else begin
        out_col++;
        if (out_col >= frame_w) begin
          out_col = 0;
          out_row++;
        end
      end
    endfunction

    // Note an accepted request
    function void note_request(in_req_t req);
      if (req.req_type == REQ_PIXEL) begin
        // Latch the frame size on the first pixel of a frame
        if (in_col == 0 && in_row == 0 && fill == 0) begin
          frame_w = fit_size(reg_w, MAX_WIDTH);
          frame_h = fit_size(reg_h, MAX_HEIGHT);
        end
        if (in_row >= frame_h) return;
        push_pixel({req.in_red, req.in_green, req.in_blue});
      end else begin
        if (in_row < frame_h) return;
        push_pixel('0);
      end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 30)
          $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    // Check a result against the oldest prediction
    function void check_result(out_res_t got);
      out_res_t want;
      if (blurred_q.size() == 0) begin
        errors++;
        if (errors <= 30)
          $display("%0t: result with nothing expected, expected none, got %p", $time, got);
        return;
      end
      want = blurred_q.pop_front();
      checked++;
      compare_field("out_red", want.out_red, got.out_red);
      compare_field("out_green", want.out_green, got.out_green);
      compare_field("out_blue", want.out_blue, got.out_blue);
      compare_field("out_alpha", want.out_alpha, got.out_alpha);
      compare_field("last_of_frame", 8'(want.last_of_frame), 8'(got.last_of_frame));
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_req_t              in_data;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_res_t             out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]    cfg_data;

  blurred_pixel_book book;
  bit                idle_on;
  int unsigned       stall_left = 0;
  int unsigned       cycle_count = 0;
  int unsigned       requests = 0;
  int unsigned       frames = 0;

  box_blur_3x3_rgb dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("box_blur_3x3_rgb verification failed");
      $finish;
    end
  end

  // Stall the result side in random bursts
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) book.check_result(out_data);
  end

  function automatic logic [CHAN_W-1:0] random_chan();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return CHAN_W'($urandom);
    endcase
  endfunction

  function automatic in_req_t make_req(logic kind, logic [CHAN_W-1:0] r,
                                       logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b);
    in_req_t req;
    req.req_type = kind;
    req.in_red   = r;
    req.in_green = g;
    req.in_blue  = b;
    return req;
  endfunction

  function automatic in_req_t random_req(logic kind);
    return make_req(kind, random_chan(), random_chan(), random_chan());
  endfunction

  // Offer one request, hold it until taken, then log it
  task automatic send_req(in_req_t req);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall !== 1'b0);
    book.note_request(req);
    requests++;
    @(negedge clk);
  endtask

  // Drain the block: no request pending, every result back, pipeline settled
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (book.blurred_q.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    book.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // One whole frame plus its drain, optionally with ignored requests and a
  // register change mid-frame mixed in
  task automatic run_frame(bit noisy, bit mid_cfg, output int unsigned n_items);
    int unsigned w, h, total, i, cut;
    send_req(random_req(REQ_PIXEL));
    w     = book.frame_w;
    h     = book.frame_h;
    total = w * h;
    cut   = (total > 1) ? $urandom_range(1, total - 1) : 0;
    for (i = 1; i < total; i++) begin
      if (noisy && $urandom_range(0, 15) == 0) send_req(random_req(REQ_FLUSH));
      if (mid_cfg && i == cut)
        write_cfg($urandom_range(0, 1) ? REG_FRAME_HEIGHT : REG_FRAME_WIDTH,
                  SIZE_W'($urandom_range(0, 12)));
      send_req(random_req(REQ_PIXEL));
    end
    // Pixels past the frame size are dropped until the last result leaves
    if (noisy) repeat ($urandom_range(1, 3)) send_req(random_req(REQ_PIXEL));
    for (i = 0; i <= w; i++) begin
      if (noisy && $urandom_range(0, 7) == 0) send_req(random_req(REQ_PIXEL));
      send_req(random_req(REQ_FLUSH));
    end
    // Flush with no frame in progress
    if (noisy && $urandom_range(0, 3) == 0) send_req(random_req(REQ_FLUSH));
    n_items = total + w + 1;
    frames++;
  endtask

  initial begin
    int unsigned n_items, wv, hv, k;
    book      = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data  = '0;
    idle_on   = 1'b1;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Small frame: extremes, stray flushes, mid-frame size change, dropped pixels
    write_cfg(REG_FRAME_WIDTH, 12'd3);
    write_cfg(REG_FRAME_HEIGHT, 12'd2);
    send_req(random_req(REQ_FLUSH));
    send_req(make_req(REQ_PIXEL, 8'd0, 8'd0, 8'd0));
    send_req(make_req(REQ_PIXEL, 8'd255, 8'd255, 8'd255));
    write_cfg(REG_FRAME_WIDTH, 12'd5);
    send_req(make_req(REQ_PIXEL, 8'd255, 8'd0, 8'd255));
    send_req(make_req(REQ_PIXEL, 8'd0, 8'd255, 8'd0));
    send_req(random_req(REQ_FLUSH));
    send_req(make_req(REQ_PIXEL, 8'd255, 8'd255, 8'd255));
    send_req(make_req(REQ_PIXEL, 8'd255, 8'd255, 8'd255));
    send_req(make_req(REQ_PIXEL, 8'd0, 8'd0, 8'd0));
    send_req(random_req(REQ_PIXEL));
    repeat (4) send_req(random_req(REQ_FLUSH));

    // Writes to unused indexes, then zero sizes that clamp to one pixel
    write_cfg(REG_UNUSED_2, '1);
    write_cfg(REG_UNUSED_3, 12'h5a5);
    write_cfg(REG_FRAME_WIDTH, 12'd0);
    write_cfg(REG_FRAME_HEIGHT, 12'd0);
    run_frame(1'b1, 1'b0, n_items);

    // Random frames, mostly small; no idling in the last stretch
    while (requests < 1050) begin
      idle_on = (requests < 870) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 11) == 0) wv = 0;
      else if ($urandom_range(0, 9) == 0) wv = $urandom_range(13, 40);
      else wv = $urandom_range(1, 12);
      if ($urandom_range(0, 11) == 0) hv = 0;
      else if ($urandom_range(0, 9) == 0) hv = $urandom_range(7, 10);
      else hv = $urandom_range(1, 6);
      write_cfg(REG_FRAME_WIDTH, SIZE_W'(wv));
      write_cfg(REG_FRAME_HEIGHT, SIZE_W'(hv));
      if ($urandom_range(0, 9) == 0)
        write_cfg($urandom_range(0, 1) ? REG_UNUSED_3 : REG_UNUSED_2, SIZE_W'($urandom));
      run_frame($urandom_range(0, 2) != 0, $urandom_range(0, 4) == 0, n_items);
    end

    // Drain and settle, then flag anything still outstanding
    in_valid <= 1'b0;
    idle_on = 1'b0;
    for (k = 0; k < 5000 && book.blurred_q.size() != 0; k++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (book.blurred_q.size() != 0) begin
      book.errors++;
      $display("%0t: %0d results expected, got none", $time, book.blurred_q.size());
    end

    $display("Covered %0d frames from 1x1 up to 40 wide and 10 tall, %0d requests taken",
             frames, requests);
    $display("%0d results checked, %0d mismatches", book.checked, book.errors);
    if (book.errors == 0) begin
      $display("box_blur_3x3_rgb verification clean");
    end else begin
      $display("box_blur_3x3_rgb verification failed");
    end
    $finish;
  end

endmodule
